// ----- rtl/brb_pkg.sv -----
`timescale 1ns / 1ps

package brb_pkg;

   localparam int DEPTH  = 64;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int QDEPTH = 2;
   localparam int QIDX_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      cnt_type    blen;
   } cmd_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_LOAD,
      ENG_STREAM
   } eng_state_type;

   localparam logic [2:0] CSR_CAPACITY_ADDR = 3'd0;

   function automatic ptr_type adv(ptr_type p, cnt_type cap);
      cnt_type nxt;
      nxt = cnt_type'(p) + cnt_type'(1);
      if (nxt >= cap) begin
         return '0;
      end
      return nxt[PTR_W-1:0];
   endfunction

endpackage

// ----- rtl/brb_front.sv -----
`timescale 1ns / 1ps

module brb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       in_func,
   input  logic [7:0]       in_data,
   input  brb_pkg::cnt_type in_blen,
   output logic             cmd_valid,
   output brb_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   brb_pkg::cmd_type                    q_ff [brb_pkg::QDEPTH];
   logic [brb_pkg::QIDX_W-1:0]          wr_idx_ff, wr_idx_in;
   logic [brb_pkg::QIDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic [brb_pkg::QCNT_W-1:0]          cnt_ff, cnt_in;
   brb_pkg::cmd_type                    entry;
   logic                                push;
   logic                                pop;

   // classify the beat
   always_comb begin
      entry.op   = brb_pkg::op_type'(in_func);
      entry.data = in_data;
      entry.blen = in_blen;
   end

   assign in_ready  = (cnt_ff != brb_pkg::QCNT_W'(brb_pkg::QDEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_idx_ff];
   assign push      = in_valid && in_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_idx_in = push ? wr_idx_ff + 1'b1 : wr_idx_ff;
      rd_idx_in = pop ? rd_idx_ff + 1'b1 : rd_idx_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_idx_ff] <= entry;
      end
   end

endmodule

// ----- rtl/brb_engine.sv -----
`timescale 1ns / 1ps

module brb_engine (
   input  logic             clock,
   input  logic             reset,
   input  brb_pkg::cnt_type capacity,
   input  logic             flush,
   input  logic             cmd_valid,
   input  brb_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_data,
   output logic             out_valid_res,
   output logic             out_last,
   output logic             out_accepted,
   output brb_pkg::cnt_type out_fill,
   output brb_pkg::cnt_type out_space
);

   logic [7:0]              mem [brb_pkg::DEPTH];

   brb_pkg::eng_state_type  state_ff, state_in;
   brb_pkg::ptr_type        wp_ff, wp_in;
   brb_pkg::ptr_type        rp_ff, rp_in;
   brb_pkg::ptr_type        p_ff, p_in;
   brb_pkg::cnt_type        held_ff, held_in;
   brb_pkg::cnt_type        rem_ff, rem_in;
   logic                    is_read_ff, is_read_in;
   logic [7:0]              rd_data_ff;
   brb_pkg::ptr_type        rd_addr;

   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              data_ff, data_in;
   logic                    vres_ff, vres_in;
   logic                    last_ff, last_in;
   logic                    acc_ff, acc_in;
   brb_pkg::cnt_type        fill_ff, fill_in;
   brb_pkg::cnt_type        space_ff, space_in;

   logic                    out_free;
   logic                    emit;
   logic                    mem_we;
   brb_pkg::cnt_type        avail;
   logic                    is_burst;

   assign out_free = !out_valid_ff || out_ready;
   assign avail    = (cmd.blen < held_ff) ? cmd.blen : held_ff;
   assign is_burst = (cmd.op == brb_pkg::OP_READ) || (cmd.op == brb_pkg::OP_PEEK);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brb_pkg::ENG_IDLE: begin
            if (cmd_valid && out_free && is_burst && (avail != '0)) begin
               state_in = brb_pkg::ENG_LOAD;
            end
         end
         brb_pkg::ENG_LOAD: begin
            state_in = brb_pkg::ENG_STREAM;
         end
         brb_pkg::ENG_STREAM: begin
            if (out_free && (rem_ff == brb_pkg::cnt_type'(1))) begin
               state_in = brb_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = brb_pkg::ENG_IDLE;
         end
      endcase
   end

   always_comb begin
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      p_in       = p_ff;
      held_in    = held_ff;
      rem_in     = rem_ff;
      is_read_in = is_read_ff;
      cmd_pop    = 1'b0;
      emit       = 1'b0;
      mem_we     = 1'b0;
      rd_addr    = p_ff;
      data_in    = 8'd0;
      vres_in    = 1'b0;
      last_in    = 1'b1;
      acc_in     = 1'b0;
      case (state_ff)
         brb_pkg::ENG_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  brb_pkg::OP_WRITE: begin
                     emit = 1'b1;
                     if (held_ff < capacity) begin
                        mem_we  = 1'b1;
                        wp_in   = brb_pkg::adv(wp_ff, capacity);
                        held_in = held_ff + 1'b1;
                        acc_in  = 1'b1;
                     end
                  end
                  brb_pkg::OP_CLEAR: begin
                     emit    = 1'b1;
                     wp_in   = '0;
                     rp_in   = '0;
                     held_in = '0;
                  end
                  default: begin
                     if (avail == '0) begin
                        emit = 1'b1;
                     end else begin
                        p_in       = rp_ff;
                        rem_in     = avail;
                        is_read_in = (cmd.op == brb_pkg::OP_READ);
                     end
                  end
               endcase
            end
         end
         brb_pkg::ENG_STREAM: begin
            if (out_free) begin
               emit    = 1'b1;
               data_in = rd_data_ff;
               vres_in = 1'b1;
               last_in = (rem_ff == brb_pkg::cnt_type'(1));
               p_in    = brb_pkg::adv(p_ff, capacity);
               rem_in  = rem_ff - 1'b1;
               rd_addr = p_in;
               if (is_read_ff) begin
                  rp_in   = p_in;
                  held_in = held_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      fill_in      = held_in;
      space_in     = capacity - held_in;
      out_valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         state_ff <= brb_pkg::ENG_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      rem_ff     <= rem_in;
      is_read_ff <= is_read_in;
      if (emit) begin
         data_ff  <= data_in;
         vres_ff  <= vres_in;
         last_ff  <= last_in;
         acc_ff   <= acc_in;
         fill_ff  <= fill_in;
         space_ff <= space_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= cmd.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign out_valid     = out_valid_ff;
   assign out_data      = data_ff;
   assign out_valid_res = vres_ff;
   assign out_last      = last_ff;
   assign out_accepted  = acc_ff;
   assign out_fill      = fill_ff;
   assign out_space     = space_ff;

endmodule

// ----- rtl/byte_ring_buffer_core.sv -----
`timescale 1ns / 1ps
// channel   direction  beat contents
// req       in         tuser: func; tdata: data_in, burst_length
// rsp       out        tuser: valid_res, accepted; tlast: last;
//                      tdata: data_out, fill_level, space_left
// csr       in/out     APB, capacity register at byte address 0
//
// Write, clear and empty read/peek: a single response beat each, issued straight from the idle state.
// Read/peek of n bytes: decode, ring memory read set-up, then one byte a cycle from the
// registered read port while rsp is not stalled.
// Synchronous reset empties the buffer and sets capacity to 64; no clearing pass.
// A two-beat command queue lets req run ahead while rsp is stalled.

module byte_ring_buffer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // data_in[7:0], burst_length[14:8], zero[15]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // data_out[7:0], fill_level[14:8], space_left[21:15]
   output logic [1:0]  rsp_tuser,  // valid_res[0], accepted[1]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   brb_pkg::cnt_type  cap_ff, cap_in;
   brb_pkg::cnt_type  wr_val;
   logic              cap_we;
   logic              cmd_valid;
   logic              cmd_pop;
   brb_pkg::cmd_type  cmd;
   logic [7:0]        out_data;
   logic              out_vres;
   logic              out_acc;
   brb_pkg::cnt_type  out_fill;
   brb_pkg::cnt_type  out_space;

   assign csr_pready = 1'b1;
   assign cap_we     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == brb_pkg::CSR_CAPACITY_ADDR);
   assign wr_val     = csr_pwdata[brb_pkg::CNT_W-1:0];

   // clamp to the usable range
   always_comb begin
      cap_in = cap_ff;
      if (cap_we) begin
         if (wr_val == '0) begin
            cap_in = brb_pkg::cnt_type'(1);
         end else if (wr_val > brb_pkg::cnt_type'(brb_pkg::DEPTH)) begin
            cap_in = brb_pkg::cnt_type'(brb_pkg::DEPTH);
         end else begin
            cap_in = wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= brb_pkg::cnt_type'(brb_pkg::DEPTH);
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign csr_prdata = (csr_paddr == brb_pkg::CSR_CAPACITY_ADDR) ? 32'(cap_ff) : 32'd0;

   brb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tuser),
      .in_data   (req_tdata[7:0]),
      .in_blen   (req_tdata[14:8]),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   brb_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .capacity      (cap_ff),
      .flush         (cap_we),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (out_data),
      .out_valid_res (out_vres),
      .out_last      (rsp_tlast),
      .out_accepted  (out_acc),
      .out_fill      (out_fill),
      .out_space     (out_space)
   );

   assign rsp_tdata = {2'b00, out_space, out_fill, out_data};
   assign rsp_tuser = {out_acc, out_vres};

endmodule

// ----- rtl/brb_checker.sv -----
`timescale 1ns / 1ps

module brb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // hold a stalled beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("status beat without last or with data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("write acknowledge carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((8'(rsp_tdata[14:8]) + 8'(rsp_tdata[21:15])) >= 8'd1)
         && ((8'(rsp_tdata[14:8]) + 8'(rsp_tdata[21:15])) <= 8'd64))
      else $error("fill plus space outside capacity range");

endmodule

bind byte_ring_buffer_core brb_checker u_brb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
